[hw/rtl/arrp_pkg.sv]
// Package: types, constants and lookup functions for the ASCII range reply parser.
package arrp_pkg;

  localparam int unsigned MaxFrameBytes = 14;
  localparam int unsigned ByteCntW      = $clog2(MaxFrameBytes + 1);

  localparam int unsigned PrefixLen = 6;
  localparam int unsigned MarkLen   = 5;

  localparam logic [15:0] MaxDistReset  = 16'd4000;
  localparam logic [15:0] OutOfRangeAdd = 16'd100;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharMinus = 8'h2d;

  localparam logic [1:0] ScaleOne  = 2'd2;
  localparam logic [1:0] ScaleZero = 2'd3;

  typedef enum logic [6:0] {
    PhPrefix    = 7'b0000001,
    PhFirst     = 7'b0000010,
    PhSpecial   = 7'b0000100,
    PhNumber    = 7'b0001000,
    PhDone      = 7'b0010000,
    PhBadPrefix = 7'b0100000,
    PhSpecialOk = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    StNumber     = 2'd0,
    StOutOfRange = 2'd1,
    StBadPrefix  = 2'd2,
    StNoDigits   = 2'd3
  } parse_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] distance_cm;
    logic [1:0]  parse_status;
  } out_item_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6c; // l
      3'd1:    c = 8'h64; // d
      3'd2:    c = 8'h6c; // l
      3'd3:    c = 8'h2c; // ,
      3'd4:    c = 8'h31; // 1
      3'd5:    c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mark_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CharMinus;
      3'd1:    c = 8'h31;
      3'd2:    c = CharDot;
      3'd3:    c = 8'h30;
      3'd4:    c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] scale_value(input logic [1:0] code);
    logic [6:0] s;
    case (code)
      2'd0:    s = 7'd100;
      2'd1:    s = 7'd10;
      2'd2:    s = 7'd1;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/ascii_range_reply_parser.sv]
// Top level: byte-serial parser for one text reply of a range sensor.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid_i/stall_o | in_item_t  (data_byte, frame_end)
//  out     | source    | out_valid_o/stall_i| out_item_t (distance_cm, parse_status)
//  cfg     | sink      | cfg_valid_i/ready_o| range limit in cm, 16 bit
//
// One byte is taken per cycle while in_stall_o is low; the parser state updates in the cycle of the transfer.
// A frame-end byte's result passes through one finish register, then a scale multiply
// into the output register.
// in_stall_o rises only when a finished frame waits behind a stalled output register.
// Reset: parser at prefix matching, range limit = 4000, no result pending.
module ascii_range_reply_parser
  import arrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] max_dist_q;

  phase_e              phase_q, phase_d;
  logic [2:0]          idx_q, idx_d;
  logic [15:0]         acc_q, acc_d;
  logic [1:0]          scale_q, scale_d;
  logic                dot_q, dot_d;
  logic                digit_q, digit_d;
  logic [ByteCntW-1:0] cnt_q, cnt_d;

  logic          fin_valid_q;
  parse_status_e fin_status_q, fin_status_d;
  logic [15:0]   fin_opnd_q, fin_opnd_d;
  logic [1:0]    fin_scale_q, fin_scale_d;

  logic      out_valid_q;
  out_item_t out_data_q;

  logic       in_xfer;
  logic       out_free;
  logic       fin_move;
  logic       byte_ok;
  logic [7:0] b;
  logic       is_digit;
  logic       is_dot;
  logic [22:0] product;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_move   = fin_valid_q && out_free;
  assign in_stall_o = fin_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  assign b        = in_data_i.data_byte;
  assign byte_ok  = cnt_q < ByteCntW'(MaxFrameBytes);
  assign is_digit = byte_ok && (b >= CharZero) && (b <= CharNine);
  assign is_dot   = byte_ok && (b == CharDot);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    scale_d = scale_q;
    dot_d   = dot_q;
    digit_d = digit_q;
    cnt_d   = byte_ok ? cnt_q + ByteCntW'(1) : cnt_q;

    case (phase_q)
      PhPrefix: begin
        if (byte_ok && (idx_q < 3'(PrefixLen)) && (b == prefix_char(idx_q))) begin
          if (idx_q == 3'(PrefixLen - 1)) begin
            phase_d = PhFirst;
            idx_d   = 3'd0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end else begin
          phase_d = PhBadPrefix;
        end
      end
      PhSpecial: begin
        if (byte_ok && (idx_q < 3'(MarkLen)) && (b == mark_char(idx_q))) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(MarkLen - 1)) begin
            phase_d = PhSpecialOk;
          end
        end else begin
          phase_d = PhDone;
        end
      end
      PhFirst, PhNumber: begin
        if ((phase_q == PhFirst) && byte_ok && (b == CharMinus)) begin
          phase_d = PhSpecial;
          idx_d   = 3'd1;
        end else if (!is_digit && !is_dot) begin
          phase_d = PhDone;
        end else begin
          phase_d = PhNumber;
          if (dot_q && (scale_q != ScaleZero)) begin
            scale_d = scale_q + 2'd1;
          end
          if (is_dot) begin
            dot_d = 1'b1;
          end else begin
            digit_d = 1'b1;
            acc_d   = (acc_q << 3) + (acc_q << 1) + {12'd0, b[3:0]};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Frame end acts as a terminator; it changes only the phase, so status comes from phase_d.
  always_comb begin
    fin_opnd_d  = 16'd0;
    fin_scale_d = ScaleOne;
    case (phase_d)
      PhPrefix, PhBadPrefix: begin
        fin_status_d = StBadPrefix;
      end
      PhSpecialOk: begin
        fin_status_d = StOutOfRange;
        fin_opnd_d   = max_dist_q + OutOfRangeAdd;
      end
      default: begin
        if (digit_d) begin
          fin_status_d = StNumber;
          fin_opnd_d   = acc_d;
          fin_scale_d  = scale_d;
        end else begin
          fin_status_d = StNoDigits;
        end
      end
    endcase
  end

  assign product = fin_opnd_q * scale_value(fin_scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MaxDistReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_dist_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      idx_q   <= 3'd0;
      acc_q   <= 16'd0;
      scale_q <= 2'd0;
      dot_q   <= 1'b0;
      digit_q <= 1'b0;
      cnt_q   <= '0;
    end else if (in_xfer) begin
      if (in_data_i.frame_end) begin
        phase_q <= PhPrefix;
        idx_q   <= 3'd0;
        acc_q   <= 16'd0;
        scale_q <= 2'd0;
        dot_q   <= 1'b0;
        digit_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        acc_q   <= acc_d;
        scale_q <= scale_d;
        dot_q   <= dot_d;
        digit_q <= digit_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer && in_data_i.frame_end) begin
        fin_valid_q <= 1'b1;
      end else if (fin_move) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.frame_end) begin
      fin_status_q <= fin_status_d;
      fin_opnd_q   <= fin_opnd_d;
      fin_scale_q  <= fin_scale_d;
    end
    if (fin_move) begin
      out_data_q.distance_cm  <= product[15:0];
      out_data_q.parse_status <= fin_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[bench/tb_top.sv]
// Testbench for ascii_range_reply_parser: directed and random replies checked by a scoreboard.
module tb_top;
  import arrp_pkg::*;

  localparam logic [8*PrefixLen-1:0] ReplyPrefix    = "ldl,1:";
  localparam logic [8*MarkLen-1:0]   OutOfRangeMark = "-1.00";
  localparam logic [1:0]             ScaleHundred   = 2'd0;
  localparam logic [1:0]             ScaleTen       = 2'd1;
  localparam int unsigned            CycleLimit     = 200000;
  localparam int unsigned            HoldOffCycles  = 120;
  localparam int unsigned            PhaseItems     = 300;

  typedef logic [7:0] reply_bytes_t[$];

  function automatic logic [7:0] prefix_at(input int unsigned i);
    return ReplyPrefix[8*(PrefixLen-1-i) +: 8];
  endfunction

  function automatic logic [7:0] mark_at(input int unsigned i);
    return OutOfRangeMark[8*(MarkLen-1-i) +: 8];
  endfunction

  class range_reply_tracker;
    logic [15:0] max_dist;
    phase_e      phase;
    int unsigned match_idx;
    logic [15:0] acc;
    logic [1:0]  scale_code;
    bit          dot_seen;
    bit          digit_seen;
    int unsigned frame_bytes;
    out_item_t   expected_replies[$];
    int unsigned mismatches;

    function new();
      max_dist   = MaxDistReset;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase       = PhPrefix;
      match_idx   = 0;
      acc         = '0;
      scale_code  = ScaleHundred;
      dot_seen    = 1'b0;
      digit_seen  = 1'b0;
      frame_bytes = 0;
    endfunction

    function void number_char(input logic [7:0] b, input bit live);
      bit is_digit;
      bit is_dot;
      is_digit = live && b >= CharZero && b <= CharNine;
      is_dot   = live && b == CharDot;
      if (!is_digit && !is_dot) begin
        phase = PhDone;
        return;
      end
      phase = PhNumber;
      if (dot_seen && scale_code != ScaleZero) scale_code++;
      if (is_dot) begin
        dot_seen = 1'b1;
        return;
      end
      digit_seen = 1'b1;
      acc = 16'(32'(acc) * 32'd10 + 32'(b - CharZero));
    endfunction

    function void parse_byte(input logic [7:0] b, input bit live);
      case (phase)
        PhPrefix: begin
          if (live && match_idx < PrefixLen && b == prefix_at(match_idx)) begin
            match_idx++;
            if (match_idx >= PrefixLen) begin
              phase     = PhFirst;
              match_idx = 0;
            end
          end else begin
            phase = PhBadPrefix;
          end
        end
        PhFirst: begin
          if (live && b == mark_at(0)) begin
            phase     = PhSpecial;
            match_idx = 1;
          end else begin
            number_char(b, live);
          end
        end
        PhSpecial: begin
          if (live && match_idx < MarkLen && b == mark_at(match_idx)) begin
            match_idx++;
            if (match_idx >= MarkLen) phase = PhSpecialOk;
          end else begin
            phase = PhDone;
          end
        end
        PhNumber: number_char(b, live);
        default: ;
      endcase
    endfunction

    function logic [15:0] scaled_value();
      int unsigned factor;
      case (scale_code)
        ScaleHundred: factor = 100;
        ScaleTen:     factor = 10;
        ScaleOne:     factor = 1;
        default:      factor = 0;
      endcase
      return 16'(32'(acc) * factor);
    endfunction

    function void note_input(input in_item_t item);
      out_item_t reply;
      if (frame_bytes < MaxFrameBytes) begin
        frame_bytes++;
        parse_byte(item.data_byte, 1'b1);
      end else begin
        parse_byte(8'h00, 1'b0);
      end
      if (!item.frame_end) return;
      parse_byte(8'h00, 1'b0);
      reply.distance_cm = '0;
      case (phase)
        PhPrefix, PhBadPrefix: reply.parse_status = StBadPrefix;
        PhSpecialOk: begin
          reply.parse_status = StOutOfRange;
          reply.distance_cm  = max_dist + OutOfRangeAdd;
        end
        default: begin
          if (digit_seen) begin
            reply.parse_status = StNumber;
            reply.distance_cm  = scaled_value();
          end else begin
            reply.parse_status = StNoDigits;
          end
        end
      endcase
      expected_replies.push_back(reply);
      clear_frame();
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply: distance_cm %0d parse_status %0d",
                 $time, got.distance_cm, got.parse_status);
        return;
      end
      want = expected_replies.pop_front();
      if (got.distance_cm !== want.distance_cm) begin
        mismatches++;
        $display("%0t: distance_cm expected %0d actual %0d",
                 $time, want.distance_cm, got.distance_cm);
      end
      if (got.parse_status !== want.parse_status) begin
        mismatches++;
        $display("%0t: parse_status expected %0d actual %0d",
                 $time, want.parse_status, got.parse_status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  range_reply_tracker tracker;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 85;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  bit          hold_req      = 1'b0;
  bit          hold_taken    = 1'b0;

  ascii_range_reply_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ascii_range_reply_parser regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic reply_bytes_t text_bytes(input string s);
    reply_bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] number_char_byte();
    if ($urandom_range(5) == 0) return CharDot;
    return CharZero + 8'($urandom_range(9));
  endfunction

  function automatic reply_bytes_t random_frame();
    reply_bytes_t q;
    int unsigned  kind;
    int unsigned  cut;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
      return q;
    end
    cut = (kind >= 73 && kind < 83) ? $urandom_range(1, PrefixLen) : PrefixLen;
    for (int unsigned i = 0; i < cut; i++) q.push_back(prefix_at(i));
    if (kind < 55) begin
      repeat ($urandom_range(8)) q.push_back(number_char_byte());
    end else if (kind < 65) begin
      for (int unsigned i = 0; i < MarkLen; i++) q.push_back(mark_at(i));
    end else if (kind < 73) begin
      for (int unsigned i = 0; i < $urandom_range(1, MarkLen - 1); i++) q.push_back(mark_at(i));
    end else if (kind < 83) begin
      if ($urandom_range(1)) q[cut-1] = 8'($urandom);
      repeat ($urandom_range(3)) q.push_back(number_char_byte());
    end else begin
      repeat ($urandom_range(9, 18)) q.push_back(number_char_byte());
    end
    repeat ($urandom_range(2)) q.push_back($urandom_range(1) ? number_char_byte() : 8'($urandom));
    return q;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_input(item);
  endtask

  task automatic send_frame(input reply_bytes_t bytes);
    in_item_t item;
    foreach (bytes[i]) begin
      item.data_byte = bytes[i];
      item.frame_end = (i == bytes.size() - 1);
      send_item(item);
    end
  endtask

  task automatic send_random_frames(input int unsigned count);
    reply_bytes_t frame;
    int unsigned  sent;
    sent = 0;
    while (sent < count) begin
      frame = random_frame();
      send_frame(frame);
      sent += frame.size();
    end
  endtask

  // drop valid, drain pending replies, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_dist(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.max_dist = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    reply_bytes_t single;
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    single = {8'h00};
    send_frame(single);
    single = {8'hff};
    send_frame(single);
    send_frame(text_bytes("ld"));
    send_frame(text_bytes("ldl,1:."));
    send_frame(text_bytes("ldl,1:-1.00"));
    settle();

    write_max_dist(16'd65435);
    send_frame(text_bytes("ldl,1:-1.00"));
    send_random_frames(PhaseItems);
    settle();

    send_idle_pct = 85;
    recv_idle_pct = 33;
    write_max_dist(16'd0);
    send_frame(text_bytes("ldl,1:-1.00"));
    send_random_frames(PhaseItems);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_dist(16'($urandom_range(65435)));
    hold_req = 1'b1;
    send_random_frames(PhaseItems);
    settle();

    if (tracker.mismatches == 0) begin
      $display("ascii_range_reply_parser regression: pass");
    end else begin
      $display("ascii_range_reply_parser regression: fail");
    end
    $finish;
  end

endmodule
